// ===== rtl/core/rbt_pkg.sv =====
// Package for the ray / Bezier tube intersect unit.
// Types and constants shared by the controller and datapath.
package rbt_pkg;
    localparam int unsigned SampleStepsDefault = 16;
    localparam int unsigned CoordW = 32;
    localparam int unsigned ParamW = 17;
    localparam int unsigned RadiusW = 23;
    localparam int unsigned AddrW = 1;
    localparam logic [AddrW-1:0] RegTubeRadius = 1'b0;
    localparam logic OpLoad = 1'b0;
    localparam logic OpTrace = 1'b1;

    // datapath micro-operations
    typedef enum logic [3:0] {
        CMD_NONE   = 4'd0,
        CMD_INIT   = 4'd1,
        CMD_WEIGHT = 4'd2,
        CMD_CURVE  = 4'd3,
        CMD_PROJ   = 4'd4,
        CMD_RAYPT  = 4'd5,
        CMD_DIST   = 4'd6,
        CMD_UPDATE = 4'd7,
        CMD_HITPT  = 4'd8,
        CMD_NEXT   = 4'd9
    } t_cmd;

    typedef struct packed {
        t_cmd       cmd;
        logic [1:0] lane;   // axis 0..2
        logic [1:0] term;   // Bezier term 0..2
    } t_ctrl;

    typedef struct packed {
        logic in_window;
        logic last_sample;
    } t_stat;
endpackage

// ===== rtl/core/rbt_if.sv =====
// Valid / ready channel interface for the intersect unit.
// Depends on nothing; payload width set by parameter.
interface rbt_if #(parameter int unsigned W = 32) (input logic i_clk);
    logic         valid;
    logic         ready;
    logic [W-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/core/rbt_datapath.sv =====
// Datapath: control point store, sample registers and one multiplier shared by the micro-operations.
// Depends on rbt_pkg; sequenced by rbt_ctrl.
module rbt_datapath #(
    parameter int unsigned SAMPLE_STEPS = rbt_pkg::SampleStepsDefault
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_load,
    input  logic [1:0]           i_point_index,
    input  logic                 i_start,
    input  logic [32*8-1:0]      i_ray,
    input  logic [22:0]          i_radius,
    input  rbt_pkg::t_ctrl       i_ctrl,
    output rbt_pkg::t_stat       o_stat,
    output logic [241:0]         o_result
);
    import rbt_pkg::*;
    localparam int unsigned IW = $clog2(SAMPLE_STEPS + 2);
    localparam logic [16:0] Step = 17'(65536 / SAMPLE_STEPS);

    logic signed [31:0] r_cx [3];
    logic signed [31:0] r_cy [3];
    logic signed [31:0] r_cz [3];
    logic signed [31:0] r_o [3];
    logic signed [31:0] r_d [3];
    logic signed [31:0] r_near, r_best_t;
    logic signed [31:0] r_cp [3];
    logic signed [31:0] r_bp [3];
    logic signed [33:0] r_acc;       // curve sum, pre-saturation
    logic signed [49:0] r_hi;
    logic [17:0]        r_lo;
    logic signed [49:0] r_tp;        // full width, may lie far outside 32 bits
    logic signed [17:0] r_df [3];
    logic               r_outside;
    logic [33:0]        r_sum;
    logic [16:0]        r_u, r_best_u;
    logic [16:0]        r_w [3];
    logic [IW-1:0]      r_i;
    logic               r_hit;
    logic signed [31:0] r_hp [3];
    logic signed [31:0] r_nm [3];

    logic signed [31:0] lane_p;
    logic signed [65:0] prod;
    logic signed [32:0] mul_a;
    logic signed [32:0] mul_b;
    logic [15:0]        rq;
    logic [33:0]        r2;
    logic [1:0]         l, tm;

    assign l = i_ctrl.lane;
    assign tm = i_ctrl.term;
    assign rq = 16'(i_radius >> 8);
    assign r2 = ({18'd0, rq} * {18'd0, rq} == 34'd0) ? 34'd4 : {18'd0, rq} * {18'd0, rq};

    always_comb begin
        case (l)
            2'd0: lane_p = r_cx[tm];
            2'd1: lane_p = r_cy[tm];
            default: lane_p = r_cz[tm];
        endcase
    end

    // one multiplier, operands chosen per command
    always_comb begin
        logic [16:0] om;
        om = 17'(18'd65536 - {1'b0, r_u});
        mul_a = '0;
        mul_b = '0;
        case (i_ctrl.cmd)
            CMD_WEIGHT: begin
                case (tm)
                    2'd0: begin mul_a = {16'd0, om}; mul_b = {16'd0, om}; end
                    2'd1: begin mul_a = {16'd0, om}; mul_b = {16'd0, r_u}; end
                    default: begin mul_a = {16'd0, r_u}; mul_b = {16'd0, r_u}; end
                endcase
            end
            CMD_CURVE: begin mul_a = {16'd0, r_w[tm]}; mul_b = 33'(lane_p); end
            CMD_PROJ:  begin mul_a = 33'(r_cp[l]) - 33'(r_o[l]); mul_b = 33'(r_d[l]); end
            CMD_RAYPT: begin mul_a = 33'(r_d[l]); mul_b = 33'(r_tp); end
            CMD_DIST:  begin mul_a = 33'(r_df[l]); mul_b = 33'(r_df[l]); end
            CMD_HITPT: begin mul_a = 33'(r_d[l]); mul_b = 33'(r_best_t); end
            default: ;
        endcase
    end
    assign prod = mul_a * mul_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 3; k++) begin
                r_cx[k] <= '0; r_cy[k] <= '0; r_cz[k] <= '0;
            end
        end else if (i_load && i_point_index != 2'd3) begin
            r_cx[i_point_index] <= i_ray[31:0];
            r_cy[i_point_index] <= i_ray[63:32];
            r_cz[i_point_index] <= i_ray[95:64];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            for (int k = 0; k < 3; k++) begin
                r_o[k] <= i_ray[32*k +: 32];
                r_d[k] <= i_ray[96 + 32*k +: 32];
                r_bp[k] <= '0;
            end
            r_near <= i_ray[223:192];
            r_best_t <= i_ray[255:224];
            r_best_u <= '0;
            r_hit <= 1'b0;
            r_u <= '0;
            r_i <= '0;
        end
        case (i_ctrl.cmd)
            CMD_INIT: begin
                r_acc <= '0; r_hi <= '0; r_lo <= '0; r_sum <= '0; r_outside <= 1'b0;
            end
            CMD_WEIGHT: r_w[tm] <= (tm == 2'd1) ? 17'(prod[47:16] << 1) : 17'(prod[47:16]);
            CMD_CURVE: begin
                logic signed [33:0] s;
                s = r_acc + 34'(prod >>> 16);
                if (tm == 2'd2) begin
                    if (s < -34'sd2147483648) r_cp[l] <= 32'h8000_0000;
                    else if (s > 34'sd2147483647) r_cp[l] <= 32'h7fff_ffff;
                    else r_cp[l] <= 32'(s);
                    r_acc <= '0;
                end else begin
                    r_acc <= s;
                end
            end
            CMD_PROJ: begin
                r_hi <= r_hi + 50'(prod >>> 16);
                r_lo <= r_lo + {2'd0, prod[15:0]};
                if (l == 2'd2) r_tp <= r_hi + 50'(prod >>> 16) +
                                       50'((r_lo + {2'd0, prod[15:0]}) >> 16);
            end
            CMD_RAYPT: begin
                logic signed [49:0] df;
                df = (50'(r_o[l]) + 50'(prod >>> 16) - 50'(r_cp[l])) >>> 8;
                r_df[l] <= 18'(df);
                if (df >= 50'sd65536 || df <= -50'sd65536) r_outside <= 1'b1;
            end
            CMD_DIST: r_sum <= r_sum + 34'(prod);
            CMD_UPDATE: begin
                if (!r_outside && r_sum <= r2) begin
                    r_best_t <= 32'(r_tp);
                    r_best_u <= r_u;
                    r_hit <= 1'b1;
                    for (int k = 0; k < 3; k++) r_bp[k] <= r_cp[k];
                end
            end
            CMD_HITPT: begin
                r_hp[l] <= 32'(34'(r_o[l]) + 34'(prod >>> 16));
                r_nm[l] <= 32'(34'(r_o[l]) + 34'(prod >>> 16) - 34'(r_bp[l]));
            end
            CMD_NEXT: begin
                r_i <= r_i + 1'b1;
                r_u <= (18'(r_u) + 18'(Step) > 18'd65536) ? 17'd65536 : 17'(r_u + Step);
            end
            default: ;
        endcase
    end

    assign o_stat.in_window = (r_tp > 50'(r_near)) && (r_tp < 50'(r_best_t));
    assign o_stat.last_sample = (r_i == IW'(SAMPLE_STEPS));
    assign o_result = r_hit ?
        {1'b1, r_best_t, r_best_u, r_hp[0], r_hp[1], r_hp[2], r_nm[0], r_nm[1], r_nm[2]} :
        {1'b0, r_best_t, 17'd0, 192'd0};
endmodule

// ===== rtl/core/rbt_ctrl.sv =====
// Controller FSM sequencing per-sample micro-operations.
// Depends on rbt_pkg; drives rbt_datapath.
module rbt_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  rbt_pkg::t_stat i_stat,
    input  logic           i_out_ready,
    output rbt_pkg::t_ctrl o_ctrl,
    output logic           o_busy,
    output logic           o_out_valid
);
    import rbt_pkg::*;
    typedef enum logic [8:0] {
        S_IDLE = 9'b000000001, S_INIT = 9'b000000010, S_WGT = 9'b000000100,
        S_CRV = 9'b000001000, S_PROJ = 9'b000010000, S_RAY = 9'b000100000,
        S_DIST = 9'b001000000, S_HIT = 9'b010000000, S_OUT = 9'b100000000
    } t_state;
    t_state r_state, n_state;
    logic [1:0] r_l, n_l, r_t, n_t;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE; r_l <= '0; r_t <= '0;
        end else begin
            r_state <= n_state; r_l <= n_l; r_t <= n_t;
        end
    end

    always_comb begin
        n_state = r_state; n_l = r_l; n_t = r_t;
        o_ctrl = '{cmd: CMD_NONE, lane: r_l, term: r_t};
        case (r_state)
            S_IDLE: if (i_start) begin n_state = S_INIT; n_l = '0; n_t = '0; end
            S_INIT: begin o_ctrl.cmd = CMD_INIT; n_state = S_WGT; end
            S_WGT: begin
                o_ctrl.cmd = CMD_WEIGHT;
                if (r_t == 2'd2) begin n_t = '0; n_state = S_CRV; end
                else n_t = r_t + 1'b1;
            end
            S_CRV: begin
                o_ctrl.cmd = CMD_CURVE;
                if (r_t == 2'd2) begin
                    n_t = '0;
                    if (r_l == 2'd2) begin n_l = '0; n_state = S_PROJ; end
                    else n_l = r_l + 1'b1;
                end else n_t = r_t + 1'b1;
            end
            S_PROJ: begin
                o_ctrl.cmd = CMD_PROJ;
                if (r_l == 2'd2) begin n_l = '0; n_state = S_RAY; end
                else n_l = r_l + 1'b1;
            end
            S_RAY: begin
                // window test on the new projection before spending more cycles
                if (!i_stat.in_window) begin
                    o_ctrl.cmd = CMD_NEXT;
                    n_state = i_stat.last_sample ? S_HIT : S_INIT;
                end else begin
                    o_ctrl.cmd = CMD_RAYPT;
                    if (r_l == 2'd2) begin n_l = '0; n_state = S_DIST; end
                    else n_l = r_l + 1'b1;
                end
            end
            S_DIST: begin
                if (r_l == 2'd3) begin
                    // update, then S_HIT advances to the next sample
                    o_ctrl.cmd = CMD_UPDATE; o_ctrl.lane = '0;
                    n_l = '0; n_t = 2'd3; n_state = S_HIT;
                end else begin
                    o_ctrl.cmd = CMD_DIST;
                    n_l = r_l + 1'b1;
                end
            end
            S_HIT: begin
                if (r_t == 2'd3) begin
                    o_ctrl.cmd = CMD_NEXT; n_t = '0;
                    n_state = i_stat.last_sample ? S_HIT : S_INIT;
                end else begin
                    o_ctrl.cmd = CMD_HITPT;
                    if (r_l == 2'd2) begin n_l = '0; n_state = S_OUT; end
                    else n_l = r_l + 1'b1;
                end
            end
            S_OUT: if (i_out_ready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    assign o_busy = (r_state != S_IDLE);
    assign o_out_valid = (r_state == S_OUT);
endmodule

// ===== rtl/core/ray_bezier_tube_intersect_unit.sv =====
// Ray against quadratic Bezier tube intersect unit, top level.
// Holds the config register and joins rbt_ctrl and rbt_datapath.
//
// Input channel (rbt_if sink): op, point_index, coord, dir, near/far limit.
// A load item writes one control point and gives no result.
// A trace item samples the curve at SAMPLE_STEPS+1 points on one shared
// multiplier: per sample an init step, weight, curve and projection steps
// and an advance step, with ray-point, distance and update steps before
// the advance when the projection lies in the window; then hit-point
// steps. The unit takes no new item while a trace is in progress.
// The result sits in the output register until taken; a new item is taken
// only once it has left. A stalled receiver holds the unit.
// Reset clears control points, tube radius and the controller.
// APB: tube_radius at address 0; pready always high.
module ray_bezier_tube_intersect_unit #(
    parameter int unsigned SAMPLE_STEPS = rbt_pkg::SampleStepsDefault
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    rbt_if.sink                        in_ch,
    rbt_if.source                      out_ch,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [rbt_pkg::AddrW+1:0]  paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready
);
    import rbt_pkg::*;
    logic [22:0] r_radius;
    t_ctrl ctrl;
    t_stat stat;
    logic busy, acc, load, start;
    logic [241:0] res;

    assign pready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_radius <= '0;
        else if (psel && penable && pwrite && paddr[AddrW+1:2] == RegTubeRadius)
            r_radius <= pwdata[22:0];
    end
    assign prdata = (paddr[AddrW+1:2] == RegTubeRadius) ? {9'd0, r_radius} : 32'd0;

    // data: {far, near, dz, dy, dx, cz, cy, cx, point_index, op}
    assign in_ch.ready = !busy;
    assign acc = in_ch.valid && !busy;
    assign load = acc && (in_ch.data[0] == OpLoad);
    assign start = acc && (in_ch.data[0] == OpTrace);

    rbt_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(start), .i_stat(stat),
        .i_out_ready(out_ch.ready), .o_ctrl(ctrl), .o_busy(busy),
        .o_out_valid(out_ch.valid)
    );
    rbt_datapath #(.SAMPLE_STEPS(SAMPLE_STEPS)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_load(load),
        .i_point_index(in_ch.data[2:1]), .i_start(start),
        .i_ray(in_ch.data[258:3]), .i_radius(r_radius), .i_ctrl(ctrl),
        .o_stat(stat), .o_result(res)
    );
    // out: {hit, ray_dist, curve_param, hx, hy, hz, nx, ny, nz}
    assign out_ch.data = res;

`ifndef SYNTH
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_ch.valid |-> !in_ch.ready) else $error("item taken while result pending");
    a_out_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.data))
        else $error("result changed under stall");
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start |=> busy) else $error("trace did not start");
`endif
endmodule
